// ----- rtl/avlw_pkg.sv -----
// Shared types, codes and constants for the ADC voltage LCD writer.
// No dependencies; every other file in rtl uses it by scoped names.
package avlw_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int VOLT_BITS   = SAMPLE_BITS - 1;  // hundredths of a volt

  localparam int HOLD_BITS   = 17;
  localparam int IDX_BITS    = 4;

  // request kinds
  localparam logic KIND_INIT   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // work codes passed from front to back
  localparam logic [1:0] OP_INIT = 2'd0;
  localparam logic [1:0] OP_HOME = 2'd1;
  localparam logic [1:0] OP_SHOW = 2'd2;

  // display commands and characters
  localparam logic [3:0] WAKE_NIBBLE  = 4'h3;
  localparam logic [3:0] BUS4_NIBBLE  = 4'h2;
  localparam logic [7:0] LCD_FUNC_SET = 8'h28;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
  localparam logic [7:0] LCD_CLEAR    = 8'h01;
  localparam logic [7:0] LCD_ENTRY    = 8'h06;
  localparam logic [7:0] LCD_HOME     = 8'h02;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_POINT   = 8'h2E;

  // hold times in microseconds
  localparam logic [HOLD_BITS-1:0] HOLD_NONE       = 17'd0;
  localparam logic [HOLD_BITS-1:0] HOLD_CMD        = 17'd250;
  localparam logic [HOLD_BITS-1:0] HOLD_CLEAR_INIT = 17'd5250;
  localparam logic [HOLD_BITS-1:0] HOLD_SETTLE     = 17'd100250;
  localparam logic [HOLD_BITS-1:0] HOLD_CLEAR      = 17'd5500;
  localparam logic [HOLD_BITS-1:0] HOLD_HOME       = 17'd1780;

  // final transfer index of each sequence
  localparam logic [IDX_BITS-1:0] INIT_LAST = 4'd13;
  localparam logic [IDX_BITS-1:0] HOME_LAST = 4'd1;
  localparam logic [IDX_BITS-1:0] SHOW_LAST = 4'd9;
  localparam logic [IDX_BITS-1:0] INIT_NIBBLES = 4'd4;

  typedef struct packed {
    logic       kind;
    logic [9:0] sample;
  } in_item_t;

  typedef struct packed {
    logic                 reg_select;
    logic [3:0]           nibble;
    logic [HOLD_BITS-1:0] hold_us;
    logic                 last;
  } out_item_t;

  // one queued piece of work
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] hund_char;
    logic [3:0] tens;
    logic [3:0] ones;
  } work_t;

endpackage

// ----- rtl/avlw_front.sv -----
// Front end: accepts requests, classifies them against the stored sample
// and works out the three display digits. Uses avlw_pkg.
module avlw_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  avlw_pkg::in_item_t cmd,
  output logic               push_valid,
  input  logic               push_ready,
  output avlw_pkg::work_t    push_data
);

  localparam int SB = avlw_pkg::SAMPLE_BITS;
  localparam int VB = avlw_pkg::VOLT_BITS;

  logic [SB-1:0] s;
  logic [SB-1:0] previous_sample;
  logic          accept;
  logic [1:0]    op_in;
  logic [SB+6:0] volt_prod;
  logic [VB+12:0] quot_prod;
  logic [VB-1:0] hund_scaled;

  logic          s1_valid, s2_valid, s3_valid;
  logic [1:0]    s1_op, s2_op, s3_op;
  logic [VB-1:0] s1_v, s2_v, s2_q, s3_q;
  logic [6:0]    s3_rem;
  logic          en1, en2, en3;
  logic [7:0]    split;

  function automatic logic [7:0] split_rem(logic [6:0] r);
    logic [3:0] t;
    logic [6:0] base;
    t = '0;
    for (int i = 1; i < 10; i++) begin
      if (r >= 7'(i * 10)) t = 4'(i);
    end
    base = 7'({3'b000, t} * 7'd10);
    return {t, 4'(r - base)};
  endfunction

  assign s = SB'(cmd.sample);

  assign en3 = !s3_valid || push_ready;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign cmd_ready = en1 && !rst;
  assign accept = cmd_valid && cmd_ready;

  always_comb begin
    if (cmd.kind == avlw_pkg::KIND_INIT)  op_in = avlw_pkg::OP_INIT;
    else if (s == previous_sample)        op_in = avlw_pkg::OP_HOME;
    else                                  op_in = avlw_pkg::OP_SHOW;
  end

  // sample*500/1024 = sample*125/256; then /100 by reciprocal 5243/2^19
  assign volt_prod   = {7'b0, s} * (SB + 7)'(125);
  assign quot_prod   = {13'b0, s1_v} * (VB + 13)'(5243);
  assign hund_scaled = VB'(s2_q * VB'(100));

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (accept) begin
        unique case (op_in)
          avlw_pkg::OP_INIT: previous_sample <= '0;
          avlw_pkg::OP_SHOW: previous_sample <= s;
          default: ;
        endcase
      end
      if (en1) s1_valid <= accept;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op <= op_in;
      s1_v  <= VB'(volt_prod >> 8);
    end
    if (en2) begin
      s2_op <= s1_op;
      s2_v  <= s1_v;
      s2_q  <= VB'(quot_prod >> 19);
    end
    if (en3) begin
      s3_op  <= s2_op;
      s3_q   <= s2_q;
      s3_rem <= 7'(s2_v - hund_scaled);
    end
  end

  assign split      = split_rem(s3_rem);
  assign push_valid = s3_valid;
  always_comb begin
    push_data.op        = s3_op;
    push_data.hund_char = 8'(avlw_pkg::CHAR_ZERO + 8'(s3_q));
    push_data.tens      = split[7:4];
    push_data.ones      = split[3:0];
  end

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == avlw_pkg::KIND_INIT) |=> previous_sample == '0)
    else $error("initialise request left a stored sample");

  a_sample_kept: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.kind == avlw_pkg::KIND_SAMPLE) |=> previous_sample == $past(s))
    else $error("stored sample does not follow the last sample request");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && !push_ready) |=> s3_valid && $stable(s3_op) && $stable(s3_rem))
    else $error("front result changed while the queue was full");

endmodule

// ----- rtl/avlw_queue.sv -----
// Two-entry queue of work records between front and back ends.
// Uses avlw_pkg for the record type.
module avlw_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  avlw_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output avlw_pkg::work_t pop_data
);

  avlw_pkg::work_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == 2'($past(count) + 2'd1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

// ----- rtl/avlw_back.sv -----
// Back end: steps through the transfer sequence of the record at the queue
// head and presents one nibble transfer a cycle while the receiver is ready. Uses avlw_pkg.
module avlw_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  avlw_pkg::work_t     pop_data,
  output logic                xfer_valid,
  input  logic                xfer_ready,
  output avlw_pkg::out_item_t xfer
);

  logic [avlw_pkg::IDX_BITS-1:0]  idx;
  logic                           load;
  logic [7:0]                     byte_v;
  logic [avlw_pkg::HOLD_BITS-1:0] hold_b;
  logic                           rs;
  logic                           direct;
  logic [3:0]                     direct_nib;
  logic                           at_last;
  avlw_pkg::out_item_t            gen;

  always_comb begin
    byte_v     = avlw_pkg::LCD_HOME;
    hold_b     = avlw_pkg::HOLD_CMD;
    rs         = 1'b0;
    direct     = 1'b0;
    direct_nib = avlw_pkg::WAKE_NIBBLE;
    at_last    = 1'b1;
    unique case (pop_data.op)
      avlw_pkg::OP_INIT: begin
        at_last = idx == avlw_pkg::INIT_LAST;
        if (idx < avlw_pkg::INIT_NIBBLES) begin
          // wake-up: three 8-bit-mode nibbles, then the switch to 4 bits
          direct     = 1'b1;
          direct_nib = (idx == 4'(avlw_pkg::INIT_NIBBLES - 4'd1)) ?
                       avlw_pkg::BUS4_NIBBLE : avlw_pkg::WAKE_NIBBLE;
        end else begin
          case (idx[3:1])
            3'd2:    byte_v = avlw_pkg::LCD_FUNC_SET;
            3'd3:    byte_v = avlw_pkg::LCD_DISP_ON;
            3'd4: begin
              byte_v = avlw_pkg::LCD_CLEAR;
              hold_b = avlw_pkg::HOLD_CLEAR_INIT;
            end
            3'd5: begin
              byte_v = avlw_pkg::LCD_ENTRY;
              hold_b = avlw_pkg::HOLD_SETTLE;
            end
            default: begin
              byte_v = avlw_pkg::LCD_CLEAR;
              hold_b = avlw_pkg::HOLD_CLEAR;
            end
          endcase
        end
      end
      avlw_pkg::OP_HOME: begin
        at_last = idx == avlw_pkg::HOME_LAST;
        byte_v  = avlw_pkg::LCD_HOME;
        hold_b  = avlw_pkg::HOLD_HOME;
      end
      avlw_pkg::OP_SHOW: begin
        at_last = idx == avlw_pkg::SHOW_LAST;
        rs      = idx[3:1] != 3'd0;
        case (idx[3:1])
          3'd0: begin
            byte_v = avlw_pkg::LCD_CLEAR;
            hold_b = avlw_pkg::HOLD_CLEAR;
          end
          3'd1:    byte_v = pop_data.hund_char;
          3'd2:    byte_v = avlw_pkg::CHAR_POINT;
          3'd3:    byte_v = {avlw_pkg::CHAR_ZERO[7:4], pop_data.tens};
          default: byte_v = {avlw_pkg::CHAR_ZERO[7:4], pop_data.ones};
        endcase
      end
      default: ;
    endcase

    gen.reg_select = rs;
    gen.last       = at_last;
    if (direct) begin
      gen.nibble  = direct_nib;
      gen.hold_us = hold_b;
    end else begin
      // high half first; hold only after the low half
      gen.nibble  = idx[0] ? byte_v[3:0] : byte_v[7:4];
      gen.hold_us = idx[0] ? hold_b : avlw_pkg::HOLD_NONE;
    end
  end

  assign load      = pop_valid && (!xfer_valid || xfer_ready);
  assign pop_ready = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      xfer_valid <= 1'b0;
    end else if (load) begin
      xfer_valid <= 1'b1;
      idx        <= at_last ? '0 : 4'(idx + 4'd1);
    end else if (xfer_ready) begin
      xfer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) xfer <= gen;
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    pop_valid |-> idx <= avlw_pkg::INIT_LAST)
    else $error("sequence index ran past the longest sequence");

  a_home_len: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_data.op == avlw_pkg::OP_HOME) |-> idx <= avlw_pkg::HOME_LAST)
    else $error("return-home sequence too long");

  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    pop_ready |=> xfer_valid && xfer.last && idx == '0)
    else $error("queue entry retired without a final transfer");

  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    !pop_valid |-> idx == '0)
    else $error("sequence index left mid-way with the queue empty");

endmodule

// ----- rtl/adc_voltage_lcd_writer.sv -----
// ADC voltage LCD writer, top level: front end, two-entry queue, back end.
// Uses avlw_pkg, avlw_front, avlw_queue and avlw_back.
//
// Turns requests into nibble transfers for a 4-bit character LCD. An
// initialise request gives 14 transfers and clears the stored sample; a
// sample equal to the stored one gives 2 (return home); any other sample
// gives 10 (clear, then the voltage as d.dd). The back end presents one
// transfer per cycle from its output register while the receiver is ready,
// and a request already queued follows the one before it with no gap.
// A request passes the three digit pipeline stages before it reaches the
// queue; the front keeps accepting while the back is busy, until the
// two-entry queue and the three pipeline stages are full.
module adc_voltage_lcd_writer (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  avlw_pkg::in_item_t  cmd,
  output logic                xfer_valid,
  input  logic                xfer_ready,
  output avlw_pkg::out_item_t xfer
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  avlw_pkg::work_t push_data, pop_data;

  avlw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  avlw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  avlw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .xfer_valid (xfer_valid),
    .xfer_ready (xfer_ready),
    .xfer       (xfer)
  );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Testbench for adc_voltage_lcd_writer: random and directed requests against an in-bench
// model of the LCD nibble stream, with random idling on both handshakes.
// Depends on avlw_pkg and the RTL top level only.
module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int RANDOM_ITEMS   = 390;

  typedef struct {
    avlw_pkg::in_item_t req;
    bit                 drain_first;  // wait for every expected transfer before offering
  } pending_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  avlw_pkg::in_item_t  cmd = '0;
  logic                xfer_valid;
  logic                xfer_ready = 1'b0;
  avlw_pkg::out_item_t xfer;

  pending_t                         pending[$];
  avlw_pkg::out_item_t              exp_xfers[$];
  logic [avlw_pkg::SAMPLE_BITS-1:0] shown_sample;
  int unsigned                      n_requests;
  int unsigned                      n_xfers;
  int unsigned                      errors;
  int unsigned                      idle_cycles;
  int unsigned                      send_gap;
  int unsigned                      recv_stall;
  int unsigned                      hold_left;
  bit                               held_once;

  adc_voltage_lcd_writer DUT (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .xfer_valid (xfer_valid),
    .xfer_ready (xfer_ready),
    .xfer       (xfer)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, some long; every fourth stretch of 32 has none
  function automatic int unsigned pick_gap(input int unsigned count);
    int unsigned r;
    if ((count / 32) % 4 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_nibble(input logic rs, input logic [3:0] nib,
                                      input logic [avlw_pkg::HOLD_BITS-1:0] hold,
                                      input logic fin);
    avlw_pkg::out_item_t x;
    x.reg_select = rs;
    x.nibble     = nib;
    x.hold_us    = hold;
    x.last       = fin;
    exp_xfers.push_back(x);
  endfunction

  function automatic void push_byte(input logic rs, input logic [7:0] b,
                                    input logic [avlw_pkg::HOLD_BITS-1:0] hold,
                                    input logic fin);
    push_nibble(rs, b[7:4], avlw_pkg::HOLD_NONE, 1'b0);
    push_nibble(rs, b[3:0], hold, fin);
  endfunction

  // expected LCD transfers for one accepted request
  function automatic void predict_xfers(input avlw_pkg::in_item_t c);
    logic [avlw_pkg::SAMPLE_BITS-1:0] s;
    logic [19:0]                      centivolts;
    logic [7:0]                       d2, d1, d0;
    s = c.sample[avlw_pkg::SAMPLE_BITS-1:0];
    if (c.kind == avlw_pkg::KIND_INIT) begin
      repeat (3) push_nibble(1'b0, avlw_pkg::WAKE_NIBBLE, avlw_pkg::HOLD_CMD, 1'b0);
      push_nibble(1'b0, avlw_pkg::BUS4_NIBBLE, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b0, avlw_pkg::LCD_FUNC_SET, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b0, avlw_pkg::LCD_DISP_ON, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b0, avlw_pkg::LCD_CLEAR, avlw_pkg::HOLD_CLEAR_INIT, 1'b0);
      push_byte(1'b0, avlw_pkg::LCD_ENTRY, avlw_pkg::HOLD_SETTLE, 1'b0);
      push_byte(1'b0, avlw_pkg::LCD_CLEAR, avlw_pkg::HOLD_CLEAR, 1'b1);
      shown_sample = '0;
    end else if (s == shown_sample) begin
      push_byte(1'b0, avlw_pkg::LCD_HOME, avlw_pkg::HOLD_HOME, 1'b1);
    end else begin
      shown_sample = s;
      centivolts = (20'(s) * 20'd500) >> 10;
      d2 = 8'(centivolts / 100);
      d1 = 8'((centivolts % 100) / 10);
      d0 = 8'(centivolts % 10);
      push_byte(1'b0, avlw_pkg::LCD_CLEAR, avlw_pkg::HOLD_CLEAR, 1'b0);
      push_byte(1'b1, avlw_pkg::CHAR_ZERO + d2, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b1, avlw_pkg::CHAR_POINT, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b1, avlw_pkg::CHAR_ZERO + d1, avlw_pkg::HOLD_CMD, 1'b0);
      push_byte(1'b1, avlw_pkg::CHAR_ZERO + d0, avlw_pkg::HOLD_CMD, 1'b1);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_valid && cmd_ready) begin
        predict_xfers(cmd);
        n_requests++;
        send_gap = pick_gap(n_requests);
      end
      if (cmd_valid && !cmd_ready) begin
        cmd_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (pending.size() > 0 &&
                   !(pending[0].drain_first && exp_xfers.size() > 0)) begin
        cmd       <= pending[0].req;
        cmd_valid <= 1'b1;
        void'(pending.pop_front());
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // transfer receiver, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      xfer_ready <= 1'b0;
      recv_stall = 0;
      hold_left  = 0;
      held_once  = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      xfer_ready <= 1'b0;
    end else if (!held_once && n_requests >= 60) begin
      held_once = 1'b1;
      hold_left = HOLD_OFF_LEN;
      xfer_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      xfer_ready <= 1'b0;
    end else if (xfer_valid && xfer_ready) begin
      recv_stall = pick_gap(n_xfers / 2);
      if (recv_stall > 0) begin
        recv_stall--;
        xfer_ready <= 1'b0;
      end else begin
        xfer_ready <= 1'b1;
      end
    end else begin
      xfer_ready <= 1'b1;
    end
  end

  // transfer checker
  always @(posedge clk) begin
    avlw_pkg::out_item_t want;
    if (!rst && xfer_valid && xfer_ready) begin
      n_xfers++;
      if (exp_xfers.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer rs=%0b nib=%h hold=%0d last=%0b", $time,
                 xfer.reg_select, xfer.nibble, xfer.hold_us, xfer.last);
      end else begin
        want = exp_xfers.pop_front();
        if (xfer !== want) begin
          errors++;
          $display({"%0t: transfer mismatch exp rs=%0b nib=%h hold=%0d last=%0b,",
                    " got rs=%0b nib=%h hold=%0d last=%0b"},
                   $time, want.reg_select, want.nibble, want.hold_us, want.last,
                   xfer.reg_select, xfer.nibble, xfer.hold_us, xfer.last);
        end
      end
    end
  end

  // watchdog: no handshake on either side for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (xfer_valid && xfer_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d transfers still expected", $time, exp_xfers.size());
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  function automatic void add_request(input logic k, input logic [9:0] s, input bit drain);
    pending_t p;
    p.req.kind   = k;
    p.req.sample = s;
    p.drain_first = drain;
    pending.push_back(p);
  endfunction

  initial begin
    logic [9:0]  gen_prev;
    logic [9:0]  s;
    int unsigned r;
    logic [9:0]  corners[6];
    shown_sample = '0;
    n_requests   = 0;
    n_xfers      = 0;
    errors       = 0;
    corners = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd512, 10'd511};

    // directed: init, home on unchanged, extremes, digit edges
    add_request(avlw_pkg::KIND_INIT,   10'h3FF, 1'b0);  // sample ignored on init
    add_request(avlw_pkg::KIND_SAMPLE, 10'd0,   1'b0);  // equals cleared sample -> home
    add_request(avlw_pkg::KIND_SAMPLE, 10'd1023, 1'b0); // 4.99
    add_request(avlw_pkg::KIND_SAMPLE, 10'd1023, 1'b0); // home
    add_request(avlw_pkg::KIND_SAMPLE, 10'd1,   1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd2,   1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd3,   1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd511, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd512, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd205, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd0,   1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd0,   1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'h2AA, 1'b0);
    add_request(avlw_pkg::KIND_INIT,   10'h155, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd0,   1'b0);  // home straight after init
    add_request(avlw_pkg::KIND_SAMPLE, 10'h155, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'h2AA, 1'b0);
    add_request(avlw_pkg::KIND_INIT,   10'h000, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd1022, 1'b0);
    add_request(avlw_pkg::KIND_SAMPLE, 10'd21,  1'b0);
    gen_prev = 10'd21;

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        add_request(avlw_pkg::KIND_INIT, 10'($urandom), i == 150 || i == 300);
        gen_prev = '0;
      end else begin
        if (r < 30) s = gen_prev;
        else if (r < 40) s = corners[3'($urandom_range(0, 5))];
        else s = 10'($urandom_range(0, 1023));
        add_request(avlw_pkg::KIND_SAMPLE, s, i == 150 || i == 300);
        gen_prev = s;
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() > 0 || cmd_valid) @(posedge clk);
    while (exp_xfers.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && exp_xfers.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
